// ===== rtl/ipv4p_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and constants for the dotted-decimal IPv4 text parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned OCTET_W     = 8;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned COUNT_W     = 2;
    localparam int unsigned ACC_W       = 12;   // octet * 10 + 9 fits in 12 bits

    localparam logic [CHAR_W-1:0]  CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0]  CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0]  CHAR_CR    = 8'h0D;
    localparam logic [ACC_W-1:0]   OCTET_MAX  = 12'd255;
    // Closed octets needed before the end of the text: three dots
    localparam logic [COUNT_W-1:0] DOTS_FULL  = 2'd3;

    // Character class of one input byte
    typedef struct packed {
        logic               is_digit;
        logic               is_dot;
        logic               is_white;
        logic [DIGIT_W-1:0] digit;
    } char_class_t;

    // Result of one complete text
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] address;
    } parse_result_t;

endpackage

// ===== rtl/ipv4_dotted_decimal_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ipv4_dotted_decimal_parser_unit
// Parses dotted-decimal IPv4 address text, one character per item.
// ----------------------------------------------------------------------------
// The block takes one character per item and sustains one item per clock
// cycle unless a final character waits: each character is held in an input
// register and is folded into the parse state by a single multiply-by-ten,
// add and compare in the following cycle. On the item with s_tlast set, one
// result item (ok flag on m_tuser, address on m_tdata, first octet in bits
// 31..24, zero when not ok) enters the output register as that character
// leaves the input register, at the next edge after its acceptance if the
// output register is free. The parse state is cleared at that edge for the
// next text. The input side keeps accepting while a result waits on
// m_tready; only a final character waits for a free output register.
module ipv4_dotted_decimal_parser_unit
    import ipv4p_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_in
    input  logic        s_tlast,    // last
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] address
    output logic        m_tuser     // [0] ok
);

    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_free;
    logic              advance;
    char_class_t       char_class;
    parse_result_t     result;

    // A final character may only leave when the result register is free
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Hold the accepted character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ipv4p_class u_class (
        .char_i  (in_char_reg),
        .class_o (char_class)
    );

    ipv4p_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_i   (advance),
        .class_i  (char_class),
        .last_i   (in_last_reg),
        .result_o (result)
    );

    // Load the result on the final character, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_ok_reg   <= result.ok;
            out_addr_reg <= result.address;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_ok_reg;

endmodule

// ===== rtl/ipv4p_class.sv =====
// ----------------------------------------------------------------------------
// ipv4p_class
// Sorts one character byte into digit, dot, white space or other.
// ----------------------------------------------------------------------------
module ipv4p_class
    import ipv4p_pkg::*;
(
    input  logic [CHAR_W-1:0] char_i,
    output char_class_t       class_o
);

    logic [CHAR_W-1:0] digit_full;

    // Subtract the '0' code; only the low nibble matters for real digits
    assign digit_full = char_i - CHAR_ZERO;

    always_comb begin
        class_o.is_digit = (char_i >= CHAR_ZERO) && (char_i <= CHAR_NINE);
        class_o.is_dot   = (char_i == CHAR_DOT);
        class_o.is_white = (char_i == CHAR_SPACE) ||
                           ((char_i >= CHAR_TAB) && (char_i <= CHAR_CR));
        class_o.digit    = digit_full[DIGIT_W-1:0];
    end

endmodule

// ===== rtl/ipv4p_core.sv =====
// ----------------------------------------------------------------------------
// ipv4p_core
// Parse state and its combinational update per character; builds the result
// on the final character and clears the state behind it.
// ----------------------------------------------------------------------------
module ipv4p_core
    import ipv4p_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step_i,     // one item advances this cycle
    input  char_class_t   class_i,
    input  logic          last_i,
    output parse_result_t result_o
);

    logic [OCTET_W-1:0] octet_value_reg,  octet_value_next;
    logic               have_digit_reg,   have_digit_next;
    logic [COUNT_W-1:0] octet_count_reg,  octet_count_next;
    logic [OCTET_W-1:0] done0_reg, done0_next;
    logic [OCTET_W-1:0] done1_reg, done1_next;
    logic [OCTET_W-1:0] done2_reg, done2_next;
    logic               failed_reg,       failed_next;
    logic               seen_text_reg,    seen_text_next;
    logic               trail_reg,        trail_next;

    logic [ACC_W-1:0]   acc;

    // Running value times ten plus the new digit
    assign acc = {1'b0, octet_value_reg, 3'b000} + {3'b000, octet_value_reg, 1'b0}
               + {{(ACC_W-DIGIT_W){1'b0}}, class_i.digit};

    // Update the state for the current character
    always_comb begin
        octet_value_next = octet_value_reg;
        have_digit_next  = have_digit_reg;
        octet_count_next = octet_count_reg;
        done0_next       = done0_reg;
        done1_next       = done1_reg;
        done2_next       = done2_reg;
        failed_next      = failed_reg;
        seen_text_next   = seen_text_reg;
        trail_next       = trail_reg;
        if (!failed_reg) begin
            priority if (class_i.is_white) begin
                if (seen_text_reg) begin
                    trail_next = 1'b1;
                end
            end else if (trail_reg) begin
                failed_next = 1'b1;
            end else if (class_i.is_digit) begin
                seen_text_next = 1'b1;
                if (acc > OCTET_MAX) begin
                    failed_next = 1'b1;
                end else begin
                    octet_value_next = acc[OCTET_W-1:0];
                    have_digit_next  = 1'b1;
                end
            end else if (class_i.is_dot) begin
                seen_text_next = 1'b1;
                if (!have_digit_reg || (octet_count_reg == DOTS_FULL)) begin
                    failed_next = 1'b1;
                end else begin
                    unique case (octet_count_reg)
                        2'd0:    done0_next = octet_value_reg;
                        2'd1:    done1_next = octet_value_reg;
                        default: done2_next = octet_value_reg;
                    endcase
                    octet_count_next = octet_count_reg + 1'b1;
                    octet_value_next = '0;
                    have_digit_next  = 1'b0;
                end
            end else begin
                seen_text_next = 1'b1;
                failed_next    = 1'b1;
            end
        end
    end

    // Build the result from the updated state
    always_comb begin
        result_o.ok = !failed_next && have_digit_next && (octet_count_next == DOTS_FULL);
        if (result_o.ok) begin
            result_o.address = {done0_next, done1_next, done2_next, octet_value_next};
        end else begin
            result_o.address = '0;
        end
    end

    // Advance the state; clear it behind the final character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            octet_value_reg <= '0;
            have_digit_reg  <= 1'b0;
            octet_count_reg <= '0;
            done0_reg       <= '0;
            done1_reg       <= '0;
            done2_reg       <= '0;
            failed_reg      <= 1'b0;
            seen_text_reg   <= 1'b0;
            trail_reg       <= 1'b0;
        end else if (step_i) begin
            if (last_i) begin
                octet_value_reg <= '0;
                have_digit_reg  <= 1'b0;
                octet_count_reg <= '0;
                done0_reg       <= '0;
                done1_reg       <= '0;
                done2_reg       <= '0;
                failed_reg      <= 1'b0;
                seen_text_reg   <= 1'b0;
                trail_reg       <= 1'b0;
            end else begin
                octet_value_reg <= octet_value_next;
                have_digit_reg  <= have_digit_next;
                octet_count_reg <= octet_count_next;
                done0_reg       <= done0_next;
                done1_reg       <= done1_next;
                done2_reg       <= done2_next;
                failed_reg      <= failed_next;
                seen_text_reg   <= seen_text_next;
                trail_reg       <= trail_next;
            end
        end
    end

    // State clears after the final character
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && last_i |=> (octet_count_reg == '0) && !failed_reg && !seen_text_reg
                             && !have_digit_reg)
        else $error("parse state not cleared after final character");

    // Trailing white space only follows text
    a_trail_needs_text: assert property (@(posedge aclk) disable iff (!aresetn)
        trail_reg |-> seen_text_reg)
        else $error("trailing space flagged without text");

    // A non-zero running octet implies a digit was taken
    a_value_needs_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (octet_value_reg != '0) |-> have_digit_reg)
        else $error("octet value without a digit");

    // A good result never carries a failure
    a_ok_not_failed: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && last_i && result_o.ok |-> !failed_reg)
        else $error("ok result after failure");

endmodule
